### sv/pcc_pkg.sv
// ----------------------------------------------------------------------------
// pcc_pkg
// Shared widths, mode codes and controller/datapath handshake types for the
// palette color cycling lookup block.
// ----------------------------------------------------------------------------
package pcc_pkg;

    localparam int CNT_W           = 9;
    localparam int CH_W            = 8;
    localparam int RGB_W           = 3 * CH_W;
    localparam int MODE_W          = 3;
    localparam int IDX_IN_W        = 8;
    localparam int DEF_MAX_ENTRIES = 256;
    localparam int DEF_COUNT_BITS  = 32;

    localparam logic [CNT_W-1:0] ENTRY_COUNT_RST = 9'd256;

    localparam logic [MODE_W-1:0] MODE_WRITE   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_LOOKUP  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_INVERT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ROT_FWD = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ROT_BWD = 3'd4;

    typedef struct packed {
        logic load_item;
        logic div_start;
        logic div_sel_count;
        logic red_load;
        logic exec;
        logic idx_load;
        logic mem_rd;
        logic out_load;
    } pcc_cmd_t;

    typedef struct packed {
        logic              dirty;
        logic [MODE_W-1:0] mode;
        logic              no_div;
        logic              div_done;
        logic              out_busy;
    } pcc_stat_t;

endpackage

### sv/pcc_if.sv
// ----------------------------------------------------------------------------
// pcc_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface pcc_in_if #(
    parameter int COUNT_BITS = pcc_pkg::DEF_COUNT_BITS
);
    import pcc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [MODE_W-1:0]     mode;
    logic [IDX_IN_W-1:0]   entry_index;
    logic [CH_W-1:0]       entry_red;
    logic [CH_W-1:0]       entry_green;
    logic [CH_W-1:0]       entry_blue;
    logic [COUNT_BITS-1:0] iteration_count;

    modport source (
        output valid, mode, entry_index, entry_red, entry_green, entry_blue,
        output iteration_count,
        input  ready
    );
    modport sink (
        input  valid, mode, entry_index, entry_red, entry_green, entry_blue,
        input  iteration_count,
        output ready
    );
endinterface

interface pcc_out_if;
    import pcc_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] color_red;
    logic [CH_W-1:0] color_green;
    logic [CH_W-1:0] color_blue;
    logic            divide_fault;

    modport source (
        output valid, color_red, color_green, color_blue, divide_fault,
        input  ready
    );
    modport sink (
        input  valid, color_red, color_green, color_blue, divide_fault,
        output ready
    );
endinterface

### sv/pcc_divider.sv
// ----------------------------------------------------------------------------
// pcc_divider
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module pcc_divider #(
    parameter int DVD_W = pcc_pkg::DEF_COUNT_BITS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [DVD_W-1:0]           dividend,
    input  logic [pcc_pkg::CNT_W-1:0]  divisor,
    output logic                       done,
    output logic [pcc_pkg::CNT_W-1:0]  rem
);
    import pcc_pkg::*;

    localparam int CW = $clog2(DVD_W + 1);

    logic             busy_reg;
    logic [CW-1:0]    step_reg;
    logic [DVD_W-1:0] dvd_reg;
    logic [CNT_W-1:0] dsr_reg;
    logic [CNT_W-1:0] rem_reg;
    logic             done_reg;
    logic [CNT_W:0]   shifted;
    logic [CNT_W:0]   diff;
    logic [CNT_W-1:0] rem_next;

    always_comb
    begin
        shifted  = {rem_reg, dvd_reg[DVD_W-1]};
        diff     = shifted - {1'b0, dsr_reg};
        // borrow means the trial subtract failed, keep the shifted value
        rem_next = diff[CNT_W] ? shifted[CNT_W-1:0] : diff[CNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == CW'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= CW'(DVD_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - CW'(1);
                if (step_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

### sv/pcc_ctrl.sv
// ----------------------------------------------------------------------------
// pcc_ctrl
// Sequencer: accepts one item, reduces the offset after a count change,
// dispatches the mode and steps a lookup through divide, read and output.
// ----------------------------------------------------------------------------
module pcc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  pcc_pkg::pcc_stat_t stat,
    output pcc_pkg::pcc_cmd_t  cmd
);
    import pcc_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_START  = 3'd1;
    localparam logic [2:0] S_RED    = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_READ   = 3'd4;
    localparam logic [2:0] S_RESULT = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_START;
                end
            end
            S_START:
            begin
                if (stat.dirty)
                begin
                    // count changed since last item, refresh reduced offset
                    cmd.div_start = 1'b1;
                    state_next    = S_RED;
                end
                else if (stat.mode == MODE_LOOKUP)
                begin
                    if (stat.no_div)
                    begin
                        cmd.idx_load = 1'b1;
                        state_next   = S_READ;
                    end
                    else
                    begin
                        cmd.div_start     = 1'b1;
                        cmd.div_sel_count = 1'b1;
                        state_next        = S_DIV;
                    end
                end
                else
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_RED:
            begin
                if (stat.div_done)
                begin
                    cmd.red_load = 1'b1;
                    state_next   = S_START;
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.idx_load = 1'b1;
                    state_next   = S_READ;
                end
            end
            S_READ:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

### sv/pcc_datapath.sv
// ----------------------------------------------------------------------------
// pcc_datapath
// Item registers, color table, rotation offset, invert flag, entry mapping,
// remainder unit and output register.
// ----------------------------------------------------------------------------
module pcc_datapath #(
    parameter int MAX_ENTRIES = pcc_pkg::DEF_MAX_ENTRIES,
    parameter int COUNT_BITS  = pcc_pkg::DEF_COUNT_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pcc_pkg::pcc_cmd_t             cmd,
    output pcc_pkg::pcc_stat_t            stat,
    input  logic [pcc_pkg::MODE_W-1:0]    mode,
    input  logic [pcc_pkg::IDX_IN_W-1:0]  entry_index,
    input  logic [pcc_pkg::CH_W-1:0]      entry_red,
    input  logic [pcc_pkg::CH_W-1:0]      entry_green,
    input  logic [pcc_pkg::CH_W-1:0]      entry_blue,
    input  logic [COUNT_BITS-1:0]         iteration_count,
    input  logic                          cfg_we,
    input  logic [pcc_pkg::CNT_W-1:0]     cfg_wdata,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [pcc_pkg::CH_W-1:0]      color_red,
    output logic [pcc_pkg::CH_W-1:0]      color_green,
    output logic [pcc_pkg::CH_W-1:0]      color_blue,
    output logic                          divide_fault
);
    import pcc_pkg::*;

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int DVD_W = (COUNT_BITS > IDX_W) ? COUNT_BITS : IDX_W;
    localparam int SUM_W = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;

    logic [MODE_W-1:0]     mode_reg;
    logic [IDX_IN_W-1:0]   idx_reg;
    logic [RGB_W-1:0]      rgb_reg;
    logic [COUNT_BITS-1:0] itc_reg;

    logic [CNT_W-1:0] entry_count_reg;
    logic [IDX_W-1:0] raw_off_reg;
    logic [IDX_W-1:0] red_off_reg;
    logic             dirty_reg;
    logic             inv_reg;
    logic [IDX_W-1:0] lidx_reg;
    logic             fault_reg;
    logic [RGB_W-1:0] rdata_reg;
    logic [RGB_W-1:0] color_reg;
    logic             ofault_reg;
    logic             out_valid_reg;

    logic [RGB_W-1:0] table_mem [MAX_ENTRIES];

    logic [CNT_W-1:0] n_eff;
    logic             escape;
    logic             no_div;
    logic [DVD_W-1:0] div_dividend;
    logic [CNT_W-1:0] div_divisor;
    logic             div_done;
    logic [CNT_W-1:0] div_rem;

    logic [SUM_W-1:0] n_ext;
    logic [SUM_W-1:0] red_ext;
    logic [SUM_W-1:0] lsel;
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] wrap;
    logic [IDX_W-1:0] slot;
    logic             slot_ok;
    logic [SUM_W-1:0] off_fwd;
    logic [SUM_W-1:0] off_bwd;

    // a count of zero acts as one, above the table size acts as the size
    always_comb
    begin
        if (entry_count_reg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (32'(entry_count_reg) > MAX_ENTRIES)
        begin
            n_eff = CNT_W'(MAX_ENTRIES);
        end
        else
        begin
            n_eff = entry_count_reg;
        end
    end

    assign escape       = &itc_reg;
    assign no_div       = escape || (n_eff < CNT_W'(2));
    assign div_dividend = cmd.div_sel_count ? DVD_W'(itc_reg) : DVD_W'(raw_off_reg);
    assign div_divisor  = cmd.div_sel_count ? (n_eff - CNT_W'(1)) : n_eff;

    pcc_divider #(
        .DVD_W (DVD_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .rem      (div_rem)
    );

    // logical to physical entry: rotate inside the count, identity beyond it
    always_comb
    begin
        n_ext   = SUM_W'(n_eff);
        red_ext = SUM_W'(red_off_reg);
        lsel    = cmd.mem_rd ? SUM_W'(lidx_reg) : SUM_W'(idx_reg);
        sum     = lsel + red_ext;
        wrap    = (sum >= n_ext) ? (sum - n_ext) : sum;
        if (lsel < n_ext)
        begin
            slot    = IDX_W'(wrap);
            slot_ok = 1'b1;
        end
        else if (32'(lsel) < MAX_ENTRIES)
        begin
            slot    = IDX_W'(lsel);
            slot_ok = 1'b1;
        end
        else
        begin
            slot    = IDX_W'(lsel);
            slot_ok = 1'b0;
        end
        off_fwd = (red_ext == '0) ? (n_ext - SUM_W'(1)) : (red_ext - SUM_W'(1));
        off_bwd = ((red_ext + SUM_W'(1)) == n_ext) ? '0 : (red_ext + SUM_W'(1));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            mode_reg <= mode;
            idx_reg  <= entry_index;
            rgb_reg  <= {entry_red, entry_green, entry_blue};
            itc_reg  <= iteration_count;
        end
        if (cmd.idx_load)
        begin
            lidx_reg  <= no_div ? '0 : IDX_W'(div_rem + CNT_W'(1));
            fault_reg <= !escape && (n_eff < CNT_W'(2));
        end
        if (cmd.out_load)
        begin
            color_reg  <= rdata_reg ^ {RGB_W{inv_reg}};
            ofault_reg <= fault_reg;
        end
    end

    // color table, stored pre-complemented while inverted
    always_ff @(posedge clk)
    begin
        if (cmd.exec && (mode_reg == MODE_WRITE) && slot_ok)
        begin
            table_mem[slot] <= rgb_reg ^ {RGB_W{inv_reg}};
        end
        if (cmd.mem_rd)
        begin
            rdata_reg <= table_mem[slot];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= ENTRY_COUNT_RST;
            raw_off_reg     <= '0;
            red_off_reg     <= '0;
            dirty_reg       <= 1'b0;
            inv_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.red_load)
            begin
                red_off_reg <= IDX_W'(div_rem);
                dirty_reg   <= 1'b0;
            end
            if (cfg_we)
            begin
                entry_count_reg <= cfg_wdata;
                dirty_reg       <= 1'b1;
            end
            if (cmd.exec)
            begin
                case (mode_reg)
                    MODE_INVERT:
                    begin
                        inv_reg <= !inv_reg;
                    end
                    MODE_ROT_FWD:
                    begin
                        raw_off_reg <= IDX_W'(off_fwd);
                        red_off_reg <= IDX_W'(off_fwd);
                    end
                    MODE_ROT_BWD:
                    begin
                        raw_off_reg <= IDX_W'(off_bwd);
                        red_off_reg <= IDX_W'(off_bwd);
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        stat.dirty    = dirty_reg;
        stat.mode     = mode_reg;
        stat.no_div   = no_div;
        stat.div_done = div_done;
        stat.out_busy = out_valid_reg && !out_ready;
    end

    assign out_valid    = out_valid_reg;
    assign color_red    = color_reg[RGB_W-1 -: CH_W];
    assign color_green  = color_reg[CH_W +: CH_W];
    assign color_blue   = color_reg[CH_W-1:0];
    assign divide_fault = ofault_reg;

endmodule

### sv/palette_color_cycling_lookup_core.sv
// ----------------------------------------------------------------------------
// palette_color_cycling_lookup_core
// Fractal palette lookup with rotation and inversion, one item at a time.
// ----------------------------------------------------------------------------
// Items are taken one at a time. Write, invert and rotate execute in the start
// state and return to idle. A lookup with a non-escape count and more than one
// entry in use runs through the bit-serial remainder unit, which walks the
// iteration count one bit per cycle; escape counts and a count of one skip it.
// The first item after a write of entry_count first reduces the rotation
// offset modulo the new count in the same unit. A finished result sits in an
// output register, so the next item is accepted while it waits to be taken.
module palette_color_cycling_lookup_core #(
    parameter int MAX_ENTRIES = pcc_pkg::DEF_MAX_ENTRIES,
    parameter int COUNT_BITS  = pcc_pkg::DEF_COUNT_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    pcc_in_if.sink                    items,
    pcc_out_if.source                 results,
    input  logic                      cfg_we,
    input  logic [pcc_pkg::CNT_W-1:0] cfg_wdata
);
    import pcc_pkg::*;

    pcc_cmd_t  cmd;
    pcc_stat_t stat;

    pcc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (items.valid),
        .in_ready (items.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pcc_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .mode            (items.mode),
        .entry_index     (items.entry_index),
        .entry_red       (items.entry_red),
        .entry_green     (items.entry_green),
        .entry_blue      (items.entry_blue),
        .iteration_count (items.iteration_count),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .out_valid       (results.valid),
        .out_ready       (results.ready),
        .color_red       (results.color_red),
        .color_green     (results.color_green),
        .color_blue      (results.color_blue),
        .divide_fault    (results.divide_fault)
    );

endmodule

### sv/pcc_checker.sv
// ----------------------------------------------------------------------------
// pcc_checker
// Port-level checks on item ordering and result bookkeeping.
// ----------------------------------------------------------------------------
module pcc_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic [pcc_pkg::MODE_W-1:0] in_mode,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [pcc_pkg::CH_W-1:0]   out_red,
    input logic [pcc_pkg::CH_W-1:0]   out_green,
    input logic [pcc_pkg::CH_W-1:0]   out_blue,
    input logic                       out_fault
);
    import pcc_pkg::*;

    logic [1:0] pending_reg;
    logic       lookup_acc;
    logic       out_acc;

    assign lookup_acc = in_valid && in_ready && (in_mode == MODE_LOOKUP);
    assign out_acc    = out_valid && out_ready;

    // lookups accepted whose result has not been taken yet
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + 2'(lookup_acc) - 2'(out_acc);
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid &&
            $stable({out_red, out_green, out_blue, out_fault}))
        else $error("result changed or dropped while stalled");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 2'd0)
        else $error("result shown without an outstanding lookup");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> pending_reg <= 2'd1)
        else $error("ready with more than one lookup outstanding");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken before the first was processed");

endmodule

bind palette_color_cycling_lookup_core pcc_checker u_pcc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (items.valid),
    .in_ready  (items.ready),
    .in_mode   (items.mode),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_red   (results.color_red),
    .out_green (results.color_green),
    .out_blue  (results.color_blue),
    .out_fault (results.divide_fault)
);
